// ===== design/modular_exponentiation_core_defines.svh =====
// ============================================================================
// modular_exponentiation_core_defines: assertion macros
// Shared property wrappers for the block's checker, clocked on clk and
// disabled while rst_n is low.
// ============================================================================
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// same-cycle implication
`define MEXP_ASSERT_IMM(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MEXP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mexp_pkg.sv =====
// ============================================================================
// mexp_pkg: shared types and constants
// Control structs between sequencer and remainder unit, register map.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index, taken from paddr above the byte offset
  localparam logic REG_MODULUS = 1'b0;

  localparam int MODULUS_RESET = 23;

  typedef struct packed {
    logic start;
  } mm_ctl_t;

  typedef struct packed {
    logic done;
  } mm_sts_t;

endpackage

`default_nettype wire

// ===== design/modular_exponentiation_core.sv =====
// ============================================================================
// modular_exponentiation_core: base^exponent mod modulus, square-and-multiply
// Steps: reduce the base, then per exponent bit a square (skipped while the value
//   is 1) and, for a later 1 bit, a multiply, each in the shared multiplier.
// One item at a time: in_ready rises in the same cycle as out_valid; the
//   bit-serial remainder in the shared multiplier sets the rate. rst_n (sync): modulus 23.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_core import mexp_pkg::*; #(
  parameter int EXP_WIDTH = 17,
  parameter int MOD_WIDTH = 31
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [MOD_WIDTH-1:0]  in_base,
  input  wire logic [EXP_WIDTH-1:0]  in_exponent,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [MOD_WIDTH-1:0]  out_power_mod,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [MOD_WIDTH-1:0] modulus_r, modulus_nxt;
  logic                 cfg_sel_mod;
  mm_ctl_t              mm_ctl;
  mm_sts_t              mm_sts;
  logic [MOD_WIDTH-1:0] mm_x;
  logic [MOD_WIDTH-1:0] mm_y;
  logic [MOD_WIDTH-1:0] mm_res;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_mod = (cfg_paddr[CFG_ADDR_W-1] == REG_MODULUS);

  always_comb begin
    modulus_nxt = modulus_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_mod) begin
      modulus_nxt = cfg_pwdata[MOD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_WIDTH'(MODULUS_RESET);
    end else begin
      modulus_r <= modulus_nxt;
    end
  end

  assign cfg_prdata = cfg_sel_mod ? CFG_DATA_W'(modulus_r) : '0;

  mexp_ctrl #(
    .EXP_WIDTH (EXP_WIDTH),
    .MOD_WIDTH (MOD_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_base       (in_base),
    .in_exponent   (in_exponent),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_power_mod (out_power_mod),
    .modulus       (modulus_r),
    .mm_ctl        (mm_ctl),
    .mm_x          (mm_x),
    .mm_y          (mm_y),
    .mm_sts        (mm_sts),
    .mm_res        (mm_res)
  );

  mexp_modmul #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mm_ctl),
    .x     (mm_x),
    .y     (mm_y),
    .m     (modulus_r),
    .sts   (mm_sts),
    .res   (mm_res)
  );

endmodule

`default_nettype wire

// ===== design/mexp_modmul.sv =====
// ============================================================================
// mexp_modmul: shared modular multiplier
// Registers the product at start, then restoring remainder, one product bit per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mexp_modmul import mexp_pkg::*; #(
  parameter int MOD_WIDTH = 31
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mm_ctl_t              ctl,
  input  wire logic [MOD_WIDTH-1:0] x,
  input  wire logic [MOD_WIDTH-1:0] y,
  input  wire logic [MOD_WIDTH-1:0] m,
  output mm_sts_t                   sts,
  output logic      [MOD_WIDTH-1:0] res
);

  localparam int PROD_W = 2 * MOD_WIDTH;
  localparam int CNT_W  = $clog2(PROD_W + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [MOD_WIDTH-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0]    prod_w;
  logic [MOD_WIDTH:0]   trial;
  logic [MOD_WIDTH:0]   m_ext;

  assign prod_w = {{MOD_WIDTH{1'b0}}, x} * {{MOD_WIDTH{1'b0}}, y};
  assign m_ext  = {1'b0, m};
  // rem < m, so trial < 2m and one conditional subtract keeps it reduced
  assign trial  = {rem_r, prod_r[PROD_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(PROD_W);
      prod_nxt = prod_w;
      rem_nxt  = '0;
    end else if (busy_r) begin
      prod_nxt = {prod_r[PROD_W-2:0], 1'b0};
      if (trial >= m_ext) begin
        rem_nxt = MOD_WIDTH'(trial - m_ext);
      end else begin
        rem_nxt = trial[MOD_WIDTH-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign sts.done = done_r;
  assign res      = rem_r;

endmodule

`default_nettype wire

// ===== design/mexp_ctrl.sv =====
// ============================================================================
// mexp_ctrl: square-and-multiply sequencer
// Scans exponent bits MSB first, drives the shared multiplier, holds result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl import mexp_pkg::*; #(
  parameter int EXP_WIDTH = 17,
  parameter int MOD_WIDTH = 31
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [MOD_WIDTH-1:0] in_base,
  input  wire logic [EXP_WIDTH-1:0] in_exponent,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [MOD_WIDTH-1:0] out_power_mod,
  input  wire logic [MOD_WIDTH-1:0] modulus,
  output mm_ctl_t                   mm_ctl,
  output logic      [MOD_WIDTH-1:0] mm_x,
  output logic      [MOD_WIDTH-1:0] mm_y,
  input  wire mm_sts_t              mm_sts,
  input  wire logic [MOD_WIDTH-1:0] mm_res
);

  localparam int IDX_W = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_BRED = 6'b000010,
    ST_STEP = 6'b000100,
    ST_SQR  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [MOD_WIDTH-1:0] b_r, b_nxt;
  logic [EXP_WIDTH-1:0] e_r, e_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [MOD_WIDTH-1:0] acc_r, acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [MOD_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                 bit_set;
  logic                 last_bit;
  logic                 acc_one;

  assign in_ready = (state_r == ST_IDLE);
  assign bit_set  = e_r[idx_r];
  assign last_bit = (idx_r == '0);
  assign acc_one  = (acc_r == MOD_WIDTH'(1));

  always_comb begin
    state_nxt     = state_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mm_ctl.start  = 1'b0;
    mm_x          = acc_r;
    mm_y          = acc_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          b_nxt   = in_base;
          e_nxt   = in_exponent;
          idx_nxt = IDX_W'(EXP_WIDTH - 1);
          acc_nxt = MOD_WIDTH'(1);
          if (modulus < MOD_WIDTH'(2)) begin
            acc_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            // reduce the base first: base * 1 mod m
            mm_ctl.start = 1'b1;
            mm_x         = in_base;
            mm_y         = MOD_WIDTH'(1);
            state_nxt    = ST_BRED;
          end
        end
      end
      ST_BRED: begin
        if (mm_sts.done) begin
          b_nxt     = mm_res;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (!acc_one) begin
          mm_ctl.start = 1'b1;
          state_nxt    = ST_SQR;
        end else begin
          // 1 squared is 1, and 1 * b mod m is the reduced base
          if (bit_set) begin
            acc_nxt = b_r;
          end
          if (last_bit) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      ST_SQR: begin
        if (mm_sts.done) begin
          acc_nxt = mm_res;
          if (bit_set) begin
            mm_ctl.start = 1'b1;
            mm_x         = mm_res;
            mm_y         = b_r;
            state_nxt    = ST_MUL;
          end else if (last_bit) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ST_STEP;
          end
        end
      end
      ST_MUL: begin
        if (mm_sts.done) begin
          acc_nxt = mm_res;
          if (last_bit) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ST_STEP;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    b_r        <= b_nxt;
    e_r        <= e_nxt;
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_power_mod = out_data_r;

endmodule

`default_nettype wire

// ===== design/mexp_checker.sv =====
// ============================================================================
// mexp_checker: port-level assertions
// Watches the top level's channels and register port; bound to the top.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "modular_exponentiation_core_defines.svh"

module mexp_checker import mexp_pkg::*; #(
  parameter int EXP_WIDTH = 17,
  parameter int MOD_WIDTH = 31
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [MOD_WIDTH-1:0]  in_base,
  input wire logic [EXP_WIDTH-1:0]  in_exponent,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [MOD_WIDTH-1:0]  out_power_mod,
  input wire logic                  cfg_psel,
  input wire logic                  cfg_penable,
  input wire logic                  cfg_pwrite,
  input wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  input wire logic [CFG_DATA_W-1:0] cfg_prdata,
  input wire logic                  cfg_pready
);

  localparam logic [CFG_DATA_W-1:0] MOD_MASK = CFG_DATA_W'((64'd1 << MOD_WIDTH) - 64'd1);

  logic                           in_xfer;
  logic                           in_wait;
  logic                           in_held;
  logic                           out_stall;
  logic                           out_held;
  logic                           mod_sel;
  logic                           mod_write;
  logic                           rd_ok;
  logic [MOD_WIDTH+EXP_WIDTH-1:0] in_data_r;
  logic [MOD_WIDTH-1:0]           out_data_r;
  logic [CFG_DATA_W-1:0]          wval_r;

  // previous-cycle copies for the hold and readback checks
  always_ff @(posedge clk) begin
    in_data_r  <= {in_base, in_exponent};
    out_data_r <= out_power_mod;
    wval_r     <= cfg_pwdata & MOD_MASK;
  end

  assign in_xfer   = in_valid && in_ready;
  assign in_wait   = in_valid && !in_ready;
  assign in_held   = in_valid && ({in_base, in_exponent} == in_data_r);
  assign out_stall = out_valid && !out_ready;
  assign out_held  = out_valid && (out_power_mod == out_data_r);
  assign mod_sel   = (cfg_paddr[CFG_ADDR_W-1] == REG_MODULUS);
  assign mod_write = cfg_psel && cfg_penable && cfg_pwrite && mod_sel;
  assign rd_ok     = !mod_sel || (cfg_prdata == wval_r);

  // one item at a time: ready drops right after an input transfer
  `MEXP_ASSERT_NXT(a_busy_after_accept, in_xfer, !in_ready, "in_ready high after a transfer")

  // a waiting input keeps its payload
  `MEXP_ASSERT_NXT(a_in_hold, in_wait, in_held, "input payload changed while waiting")

  // a stalled result holds
  `MEXP_ASSERT_NXT(a_out_hold, out_stall, out_held, "stalled result changed or dropped")

  // modulus reads back as written, truncated to MOD_WIDTH
  `MEXP_ASSERT_NXT(a_cfg_readback, mod_write, rd_ok, "modulus readback mismatch")

  // register port never inserts wait states
  `MEXP_ASSERT_IMM(a_pready, cfg_psel, cfg_pready, "pready low during a register access")

endmodule

bind modular_exponentiation_core mexp_checker #(
  .EXP_WIDTH (EXP_WIDTH),
  .MOD_WIDTH (MOD_WIDTH)
) u_mexp_checker (.*);

`default_nettype wire
